/* rtl/lst_pkg.sv */
// Shared constants and types for the LCD scanline timing block.
`default_nettype none

package lst_pkg;

   // Field widths.
   localparam int ELAPSED_W = 11;
   localparam int SUM_W     = ELAPSED_W + 1;
   localparam int LINE_W    = 8;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 4;

   // Line and frame timing.
   localparam logic [ELAPSED_W-1:0] CYCLES_PER_LINE = 11'd1232;
   localparam logic [ELAPSED_W-1:0] HBLANK_START    = 11'd960;
   localparam logic [LINE_W-1:0]    VISIBLE_LINES   = 8'd160;
   localparam logic [LINE_W-1:0]    TOTAL_LINES     = 8'd228;

   // Register indexes (byte address divided by four).
   typedef enum logic [1:0] {
      REG_HBLANK_IRQ_EN = 2'd0,
      REG_VBLANK_IRQ_EN = 2'd1,
      REG_VCOUNT_IRQ_EN = 2'd2,
      REG_VCOUNT_TARGET = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic              hblank_irq_enable;
      logic              vblank_irq_enable;
      logic              vcount_irq_enable;
      logic [LINE_W-1:0] vcount_target;
   } cfg_type;

   typedef struct packed {
      logic [ELAPSED_W-1:0] cycle_count;
      logic [LINE_W-1:0]    line_number;
      logic                 hblank_flag;
      logic                 vblank_flag;
      logic                 match_flag;
   } state_type;

   typedef struct packed {
      logic [LINE_W-1:0] line_count;
      logic              hblank_status;
      logic              vblank_status;
      logic              vcount_match_status;
      logic              hblank_dma_pulse;
      logic              vblank_dma_pulse;
      logic              hblank_irq_pulse;
      logic              vblank_irq_pulse;
      logic              vcount_irq_pulse;
      logic              render_request;
      logic [LINE_W-1:0] render_line;
   } result_type;

endpackage

`default_nettype wire

/* rtl/lst_if.sv */
// Valid/ready channel interfaces for timing ticks and timing results.
`default_nettype none

interface lst_req_if;
   logic                            valid;
   logic                            ready;
   logic [lst_pkg::ELAPSED_W-1:0]   elapsed_cycles;

   modport source (output valid, output elapsed_cycles, input ready);
   modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

interface lst_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lst_pkg::LINE_W-1:0]   line_count;
   logic                         hblank_status;
   logic                         vblank_status;
   logic                         vcount_match_status;
   logic                         hblank_dma_pulse;
   logic                         vblank_dma_pulse;
   logic                         hblank_irq_pulse;
   logic                         vblank_irq_pulse;
   logic                         vcount_irq_pulse;
   logic                         render_request;
   logic [lst_pkg::LINE_W-1:0]   render_line;

   modport source (output valid, output line_count, output hblank_status,
                   output vblank_status, output vcount_match_status,
                   output hblank_dma_pulse, output vblank_dma_pulse,
                   output hblank_irq_pulse, output vblank_irq_pulse,
                   output vcount_irq_pulse, output render_request,
                   output render_line, input ready);
   modport sink   (input valid, input line_count, input hblank_status,
                   input vblank_status, input vcount_match_status,
                   input hblank_dma_pulse, input vblank_dma_pulse,
                   input hblank_irq_pulse, input vblank_irq_pulse,
                   input vcount_irq_pulse, input render_request,
                   input render_line, output ready);
endinterface

`default_nettype wire

/* rtl/lst_csr.sv */
// APB-style configuration registers for the scanline timing block.
`default_nettype none

module lst_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [lst_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [lst_pkg::DATA_W-1:0]    pwdata,
   output      logic [lst_pkg::DATA_W-1:0]    prdata,
   output      logic                          pready,
   output      lst_pkg::cfg_type              cfg
);

   lst_pkg::cfg_type      cfg_ff;
   lst_pkg::cfg_type      cfg_in;
   lst_pkg::reg_index_type reg_sel;
   logic                  wr_en;

   assign pready  = 1'b1;
   assign reg_sel = lst_pkg::reg_index_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite && pready;
   assign cfg     = cfg_ff;

   // Write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            lst_pkg::REG_HBLANK_IRQ_EN: cfg_in.hblank_irq_enable = pwdata[0];
            lst_pkg::REG_VBLANK_IRQ_EN: cfg_in.vblank_irq_enable = pwdata[0];
            lst_pkg::REG_VCOUNT_IRQ_EN: cfg_in.vcount_irq_enable = pwdata[0];
            lst_pkg::REG_VCOUNT_TARGET:
               cfg_in.vcount_target = pwdata[lst_pkg::LINE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read decode.
   always_comb begin
      prdata = '0;
      unique case (reg_sel)
         lst_pkg::REG_HBLANK_IRQ_EN: prdata[0] = cfg_ff.hblank_irq_enable;
         lst_pkg::REG_VBLANK_IRQ_EN: prdata[0] = cfg_ff.vblank_irq_enable;
         lst_pkg::REG_VCOUNT_IRQ_EN: prdata[0] = cfg_ff.vcount_irq_enable;
         lst_pkg::REG_VCOUNT_TARGET:
            prdata[lst_pkg::LINE_W-1:0] = cfg_ff.vcount_target;
         default: prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/lst_step.sv */
// Next-state and result logic for one timing tick.
`default_nettype none

module lst_step (
   input  wire logic [lst_pkg::ELAPSED_W-1:0] elapsed_cycles,
   input  wire lst_pkg::state_type            state,
   input  wire lst_pkg::cfg_type              cfg,
   output      lst_pkg::state_type            state_next,
   output      lst_pkg::result_type           result
);

   logic [lst_pkg::ELAPSED_W-1:0] add;
   logic [lst_pkg::SUM_W-1:0]     now;
   logic [lst_pkg::SUM_W-1:0]     wrapped;
   logic [lst_pkg::LINE_W:0]      line_inc;
   logic [lst_pkg::LINE_W-1:0]    line_new;
   logic                          visible;
   logic                          hstart;
   logic                          line_end;
   logic                          vis_new;
   logic                          match_new;

   // Clamp the tick to one line and advance the cycle counter.
   assign add = (elapsed_cycles > lst_pkg::CYCLES_PER_LINE) ?
                lst_pkg::CYCLES_PER_LINE : elapsed_cycles;
   assign now = {1'b0, state.cycle_count} + {1'b0, add};
   assign wrapped = now - {1'b0, lst_pkg::CYCLES_PER_LINE};

   // Horizontal events.
   assign visible  = state.line_number < lst_pkg::VISIBLE_LINES;
   assign hstart   = (state.cycle_count < lst_pkg::HBLANK_START) &&
                     (now >= {1'b0, lst_pkg::HBLANK_START}) && visible;
   assign line_end = now >= {1'b0, lst_pkg::CYCLES_PER_LINE};

   // Line advance with wrap at the end of the frame.
   assign line_inc  = {1'b0, state.line_number} + 9'd1;
   assign line_new  = (line_inc >= {1'b0, lst_pkg::TOTAL_LINES}) ?
                      '0 : line_inc[lst_pkg::LINE_W-1:0];
   assign vis_new   = line_new >= lst_pkg::VISIBLE_LINES;
   assign match_new = line_new == cfg.vcount_target;

   // Assemble the new state and the result.
   always_comb begin
      state_next = state;
      result     = '0;

      result.hblank_dma_pulse = hstart;
      result.hblank_irq_pulse = hstart && cfg.hblank_irq_enable;
      state_next.hblank_flag  = hstart ? 1'b1 : state.hblank_flag;
      state_next.cycle_count  = now[lst_pkg::ELAPSED_W-1:0];

      if (line_end) begin
         state_next.cycle_count  = wrapped[lst_pkg::ELAPSED_W-1:0];
         state_next.hblank_flag  = 1'b0;
         result.render_request   = visible;
         result.render_line      = visible ? state.line_number : '0;
         state_next.line_number  = line_new;
         result.vblank_dma_pulse = vis_new && !state.vblank_flag;
         result.vblank_irq_pulse = vis_new && !state.vblank_flag &&
                                   cfg.vblank_irq_enable;
         state_next.vblank_flag  = vis_new;
         state_next.match_flag   = match_new;
         result.vcount_irq_pulse = match_new && cfg.vcount_irq_enable;
      end

      result.line_count          = state_next.line_number;
      result.hblank_status       = state_next.hblank_flag;
      result.vblank_status       = state_next.vblank_flag;
      result.vcount_match_status = state_next.match_flag;
   end

endmodule

`default_nettype wire

/* rtl/lcd_scanline_timing.sv */
// Top level of the LCD scanline timing generator.
//
//  Channel   Direction  Handshake               Contents
//  req_chan  in         valid/ready             elapsed_cycles
//  rsp_chan  out        valid/ready             line, flags, pulses, render
//  csr (APB) in         psel/penable, pready=1  four config registers
//
// One tick is accepted every cycle while the result side keeps up. Its result is
// loaded from the input register into the result register, and transfers out from there.
// A tick sits in an input register, then one pass of adder, compares and
// flag logic updates the timing state and loads the result register.
// Reset clears the timing state, config registers and both valid bits.
// A stalled result holds the pipeline; an empty input register takes one more
// tick, and after that req_chan.ready stays low until the result transfers.
`default_nettype none

module lcd_scanline_timing (
   input  wire logic                          clock,
   input  wire logic                          reset,
   lst_req_if.sink                            req_chan,
   lst_rsp_if.source                          rsp_chan,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [lst_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [lst_pkg::DATA_W-1:0]    pwdata,
   output      logic [lst_pkg::DATA_W-1:0]    prdata,
   output      logic                          pready
);

   lst_pkg::cfg_type               cfg;
   lst_pkg::state_type             state_ff;
   lst_pkg::state_type             state_in;
   lst_pkg::result_type            result_ff;
   lst_pkg::result_type            result_in;
   logic                           in_valid_ff;
   logic [lst_pkg::ELAPSED_W-1:0]  in_elapsed_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_load;
   logic                           req_take;

   // Configuration registers.
   lst_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Per-tick timing update.
   lst_step u_step (
      .elapsed_cycles (in_elapsed_ff),
      .state          (state_ff),
      .cfg            (cfg),
      .state_next     (state_in),
      .result         (result_in)
   );

   // Flow control between the input and result registers.
   assign rsp_load       = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || rsp_load;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_elapsed_ff <= req_chan.elapsed_cycles;
      end
      if (rsp_load) begin
         result_ff <= result_in;
      end
   end

   // Result channel outputs.
   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.line_count          = result_ff.line_count;
   assign rsp_chan.hblank_status       = result_ff.hblank_status;
   assign rsp_chan.vblank_status       = result_ff.vblank_status;
   assign rsp_chan.vcount_match_status = result_ff.vcount_match_status;
   assign rsp_chan.hblank_dma_pulse    = result_ff.hblank_dma_pulse;
   assign rsp_chan.vblank_dma_pulse    = result_ff.vblank_dma_pulse;
   assign rsp_chan.hblank_irq_pulse    = result_ff.hblank_irq_pulse;
   assign rsp_chan.vblank_irq_pulse    = result_ff.vblank_irq_pulse;
   assign rsp_chan.vcount_irq_pulse    = result_ff.vcount_irq_pulse;
   assign rsp_chan.render_request      = result_ff.render_request;
   assign rsp_chan.render_line         = result_ff.render_line;

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the LCD scanline timing generator.

module tb;

   typedef logic [lst_pkg::ELAPSED_W-1:0] elapsed_type;
   typedef logic [lst_pkg::LINE_W-1:0]    line_type;
   typedef logic [lst_pkg::DATA_W-1:0]    word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Configuration port.
   logic                       psel    = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite  = 1'b0;
   logic [lst_pkg::ADDR_W-1:0] paddr   = '0;
   word_type                   pwdata  = '0;
   word_type                   prdata;
   logic                       pready;

   lst_req_if req_chan ();
   lst_rsp_if rsp_chan ();

   lcd_scanline_timing DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Mirror of the timing state and the configuration registers.
   int                 cyc_now     = 0;
   line_type           line_now    = '0;
   logic               hblank_now  = 1'b0;
   logic               vblank_now  = 1'b0;
   logic               match_now   = 1'b0;
   lst_pkg::cfg_type   cfg_shadow  = '0;

   // Predicted status words, oldest first.
   lst_pkg::result_type scanline_q[$];

   // Traffic shaping, in percent per cycle.
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;

   // Hold-off request from the tests, and the count kept by the result side.
   int hold_len      = 0;
   int hold_gen      = 0;
   int hold_gen_seen = 0;
   int hold_left     = 0;

   int error_count   = 0;
   int ticks_sent    = 0;
   int results_seen  = 0;
   int frame_wraps   = 0;
   int vblank_starts = 0;
   int hblank_irqs   = 0;
   int match_irqs    = 0;

   always #2 clock = ~clock;

   // Apply one tick to the mirrored state and return the status it produces.
   function automatic lst_pkg::result_type advance_scanline(input elapsed_type elapsed);
      lst_pkg::result_type r;
      int                  add_cyc;
      int                  sum_cyc;
      line_type            next_line;
      logic                in_vblank;
      r = '0;
      add_cyc = (elapsed > lst_pkg::CYCLES_PER_LINE) ?
                int'(lst_pkg::CYCLES_PER_LINE) : int'(elapsed);
      sum_cyc = cyc_now + add_cyc;

      // HBlank begins only when the count crosses its start on a visible line.
      if (cyc_now < int'(lst_pkg::HBLANK_START) && sum_cyc >= int'(lst_pkg::HBLANK_START) &&
          line_now < lst_pkg::VISIBLE_LINES) begin
         r.hblank_dma_pulse = 1'b1;
         r.hblank_irq_pulse = cfg_shadow.hblank_irq_enable;
         hblank_now = 1'b1;
         if (cfg_shadow.hblank_irq_enable) hblank_irqs++;
      end

      // Line end: advance the line and refresh the frame flags.
      if (sum_cyc >= int'(lst_pkg::CYCLES_PER_LINE)) begin
         sum_cyc = sum_cyc - int'(lst_pkg::CYCLES_PER_LINE);
         hblank_now = 1'b0;
         if (line_now < lst_pkg::VISIBLE_LINES) begin
            r.render_request = 1'b1;
            r.render_line    = line_now;
         end
         next_line = line_now + 8'd1;
         if (next_line >= lst_pkg::TOTAL_LINES) begin
            next_line = '0;
            frame_wraps++;
         end
         line_now = next_line;

         in_vblank = (line_now >= lst_pkg::VISIBLE_LINES);
         if (in_vblank && !vblank_now) begin
            r.vblank_dma_pulse = 1'b1;
            r.vblank_irq_pulse = cfg_shadow.vblank_irq_enable;
            vblank_starts++;
         end
         vblank_now = in_vblank;

         match_now = (line_now == cfg_shadow.vcount_target);
         r.vcount_irq_pulse = match_now & cfg_shadow.vcount_irq_enable;
         if (r.vcount_irq_pulse) match_irqs++;
      end
      cyc_now = sum_cyc;

      r.line_count          = line_now;
      r.hblank_status       = hblank_now;
      r.vblank_status       = vblank_now;
      r.vcount_match_status = match_now;
      return r;
   endfunction

   // Mostly whole or oversized lines so that frames move along, plus partial steps.
   function automatic elapsed_type random_elapsed();
      int pick;
      pick = $urandom_range(19);
      if (pick < 10) return lst_pkg::CYCLES_PER_LINE;
      else if (pick < 14) return elapsed_type'($urandom_range(2047, 1233));
      else if (pick < 19) return elapsed_type'($urandom_range(1231));
      else return elapsed_type'($urandom_range(15));
   endfunction

   // Offer one tick, with a random idle gap ahead of it, and wait for its transfer.
   task automatic send_tick(input elapsed_type elapsed);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_chan.valid          <= 1'b1;
      req_chan.elapsed_cycles <= elapsed;
      do @(posedge clock); while (!req_chan.ready);
      scanline_q.push_back(advance_scanline(elapsed));
      ticks_sent++;
   endtask

   task automatic run_random(input int count);
      repeat (count) send_tick(random_elapsed());
   endtask

   // Stop offering ticks and wait until every predicted status has arrived.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (scanline_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Setup-then-access register write; the register takes the value at the access edge.
   task automatic write_reg(input lst_pkg::reg_index_type idx, input word_type value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         lst_pkg::REG_HBLANK_IRQ_EN: cfg_shadow.hblank_irq_enable = value[0];
         lst_pkg::REG_VBLANK_IRQ_EN: cfg_shadow.vblank_irq_enable = value[0];
         lst_pkg::REG_VCOUNT_IRQ_EN: cfg_shadow.vcount_irq_enable = value[0];
         lst_pkg::REG_VCOUNT_TARGET:
            cfg_shadow.vcount_target = value[lst_pkg::LINE_W-1:0];
         default: ;
      endcase
   endtask

   // A negative target picks a line a little ahead of the current one.
   task automatic set_config(input logic hen, input logic ven, input logic cen,
                             input int target);
      line_type tgt;
      drain_results();
      if (target < 0) tgt = line_type'((int'(line_now) + $urandom_range(30, 1)) % 228);
      else tgt = line_type'(target);
      write_reg(lst_pkg::REG_HBLANK_IRQ_EN, word_type'(hen));
      write_reg(lst_pkg::REG_VBLANK_IRQ_EN, word_type'(ven));
      write_reg(lst_pkg::REG_VCOUNT_IRQ_EN, word_type'(cen));
      write_reg(lst_pkg::REG_VCOUNT_TARGET, word_type'(tgt));
   endtask

   // Field extremes, HBlank crossings, saturation, and lines that end inside HBlank
   // or start past it.
   task automatic test_directed();
      int tick_list[18] = '{0, 1, 958, 1, 0, 272, 2047, 1000, 1232, 232,
                            1231, 1, 1024, 1365, 682, 1233, 1232, 0};
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      set_config(1'b1, 1'b1, 1'b1, 1);
      foreach (tick_list[i]) send_tick(elapsed_type'(tick_list[i]));
   endtask

   // Run through VBlank start and the frame wrap with every interrupt enabled.
   task automatic test_frame_wrap();
      int start_wraps;
      int sent;
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      set_config(1'b1, 1'b1, 1'b1, 0);
      start_wraps = frame_wraps;
      sent = 0;
      while (frame_wraps == start_wraps && sent < 500) begin
         send_tick(random_elapsed());
         sent++;
      end
   endtask

   task automatic test_sender_idle();
      tx_idle_pct  = 78;
      rx_stall_pct = 0;
      set_config(1'b0, 1'b1, 1'b0, 255);
      run_random(70);
   endtask

   task automatic test_receiver_stall();
      tx_idle_pct  = 0;
      rx_stall_pct = 78;
      set_config(1'b1, 1'b0, 1'b1, -1);
      run_random(70);
   endtask

   task automatic test_both_idle();
      tx_idle_pct  = 22;
      rx_stall_pct = 22;
      set_config(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1, -1);
      run_random(70);
   endtask

   // Hold the result side off while ticks keep coming, pause until all is in, then run more with random stalls.
   task automatic test_backpressure();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      set_config(1'b1, 1'b1, 1'b1, -1);
      hold_len = 300;
      hold_gen++;
      run_random(40);
      drain_results();
      rx_stall_pct = 22;
      run_random(40);
   endtask

   // Result side: random stalls, or a counted hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_gen != hold_gen_seen) begin
         hold_gen_seen = hold_gen;
         hold_left     = hold_len;
      end
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         error_count++;
         if (error_count <= 40)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Compare each status transfer with the oldest prediction.
   always @(posedge clock) begin
      lst_pkg::result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (scanline_q.size() == 0) begin
            error_count++;
            if (error_count <= 40)
               $display("%0t ns: status transfer with no prediction pending, actual line %0d",
                        $time, rsp_chan.line_count);
         end else begin
            want = scanline_q.pop_front();
            check_field("line_count", want.line_count, rsp_chan.line_count);
            check_field("hblank_status", want.hblank_status, rsp_chan.hblank_status);
            check_field("vblank_status", want.vblank_status, rsp_chan.vblank_status);
            check_field("vcount_match_status", want.vcount_match_status,
                        rsp_chan.vcount_match_status);
            check_field("hblank_dma_pulse", want.hblank_dma_pulse, rsp_chan.hblank_dma_pulse);
            check_field("vblank_dma_pulse", want.vblank_dma_pulse, rsp_chan.vblank_dma_pulse);
            check_field("hblank_irq_pulse", want.hblank_irq_pulse, rsp_chan.hblank_irq_pulse);
            check_field("vblank_irq_pulse", want.vblank_irq_pulse, rsp_chan.vblank_irq_pulse);
            check_field("vcount_irq_pulse", want.vcount_irq_pulse, rsp_chan.vcount_irq_pulse);
            check_field("render_request", want.render_request, rsp_chan.render_request);
            check_field("render_line", want.render_line, rsp_chan.render_line);
         end
      end
   end

   // Overall time limit.
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      req_chan.valid          = 1'b0;
      req_chan.elapsed_cycles = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_frame_wrap();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_backpressure();

      // Let any stray transfer show up before the verdict.
      drain_results();
      repeat (8) @(posedge clock);
      if (scanline_q.size() != 0) error_count++;

      $display("Sent %0d ticks and checked %0d status words over %0d frame wraps.",
               ticks_sent, results_seen, frame_wraps);
      $display("Saw %0d VBlank starts, %0d HBlank interrupts and %0d line-match interrupts.",
               vblank_starts, hblank_irqs, match_irqs);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/lst_pkg.sv
rtl/lst_if.sv
rtl/lst_csr.sv
rtl/lst_step.sv
rtl/lcd_scanline_timing.sv
sim/tb.sv
